FILE: rtl/biquad_df1_q29_filter_core_defines.svh
// Assertion macros shared by the biquad core RTL.
// Depends on nothing; the user module must provide clk and arst_n.
`ifndef BIQUAD_DF1_Q29_FILTER_CORE_DEFINES_SVH
`define BIQUAD_DF1_Q29_FILTER_CORE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define BQ_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define BQ_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/bqdf1_pkg.sv
// Shared constants, register indexes and bundles for the DF-I biquad core.
// Depends on nothing.
package bqdf1_pkg;

	localparam int SAMPLE_W    = 16;
	localparam int COEF_W      = 32;
	localparam int ACC_W       = 64;
	localparam int FRAC_SHIFT  = 29;
	localparam int WIDEN_SHIFT = 14;
	localparam int REG_IDX_W   = 3;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_FF_COEF_0 = 3'd0,
		REG_FF_COEF_1 = 3'd1,
		REG_FF_COEF_2 = 3'd2,
		REG_FB_COEF_1 = 3'd3,
		REG_FB_COEF_2 = 3'd4
	} reg_idx_t;

	typedef logic signed [COEF_W-1:0] q29_t;

	typedef struct packed {
		q29_t ff_coef_0;
		q29_t ff_coef_1;
		q29_t ff_coef_2;
		q29_t fb_coef_1;
		q29_t fb_coef_2;
	} coef_set_t;

	typedef struct packed {
		q29_t prev_in_1;
		q29_t prev_in_2;
		q29_t prev_out_1;
		q29_t prev_out_2;
	} hist_t;

endpackage

FILE: rtl/biquad_df1_q29_filter_core.sv
// Top level of the direct-form-I biquad core: handshakes, registers, history.
// Depends on bqdf1_pkg, bqdf1_datapath and biquad_df1_q29_filter_core_defines.svh.
//
//   channel | direction | handshake              | payload
//   --------+-----------+------------------------+-------------------------------
//   in      | to core   | in_valid / in_ready    | sample_in  (s16 Q15)
//   out     | from core | out_valid / out_ready  | sample_out (s16 Q15, saturated)
//   cfg     | to core   | cfg_valid / cfg_ready  | cfg_index (3b), cfg_data (32b)
//
// Each word passes through the input register and then the result register;
// one word per cycle is sustained while out_ready stays high. The path from
// the input register to the result register holds the five 32x32 products
// and their sum, with the feedback terms taken straight from the history
// registers. Reset clears coefficients and history; no clearing pass. A stall
// on out_ready holds the result register and, behind it, the input register;
// in_ready drops only when both are full and the output is stalled.
// cfg_ready is always high; writes to indexes past the last register drop.
`include "biquad_df1_q29_filter_core_defines.svh"

module biquad_df1_q29_filter_core (
	input  logic                                       clk,
	input  logic                                       arst_n,

	input  logic                                       in_valid,
	output logic                                       in_ready,
	input  logic signed [bqdf1_pkg::SAMPLE_W-1:0]      sample_in,

	output logic                                       out_valid,
	input  logic                                       out_ready,
	output logic signed [bqdf1_pkg::SAMPLE_W-1:0]      sample_out,

	input  logic                                       cfg_valid,
	output logic                                       cfg_ready,
	input  logic [bqdf1_pkg::REG_IDX_W-1:0]            cfg_index,
	input  logic [bqdf1_pkg::COEF_W-1:0]               cfg_data
);

	// Input register.
	logic                                  valid_s1;
	logic signed [bqdf1_pkg::SAMPLE_W-1:0] sample_s1;

	// Result register.
	logic                                  out_valid_q;
	logic signed [bqdf1_pkg::SAMPLE_W-1:0] sample_out_q;

	bqdf1_pkg::coef_set_t coef_q;
	bqdf1_pkg::hist_t     hist_q;

	bqdf1_pkg::q29_t                       x29;
	bqdf1_pkg::q29_t                       y29;
	logic signed [bqdf1_pkg::SAMPLE_W-1:0] y15;
	logic                                  advance;
	logic                                  fire;

	// The result register can take a new word when it is empty or being drained.
	assign advance   = !out_valid_q || out_ready;
	assign fire      = valid_s1 && advance;
	assign in_ready  = !valid_s1 || advance;
	assign out_valid = out_valid_q;
	assign sample_out = sample_out_q;
	assign cfg_ready = 1'b1;

	// Widen Q15 to Q29: shift left by 14, sign-extend to 32 bits.
	assign x29 = {{(bqdf1_pkg::COEF_W - bqdf1_pkg::SAMPLE_W - bqdf1_pkg::WIDEN_SHIFT)
	              {sample_s1[bqdf1_pkg::SAMPLE_W-1]}},
	              sample_s1, {bqdf1_pkg::WIDEN_SHIFT{1'b0}}};

	bqdf1_datapath u_datapath (
		.x29  (x29),
		.coef (coef_q),
		.hist (hist_q),
		.y29  (y29),
		.y15  (y15)
	);

	// Input register: load on accept, empty when its word moves on.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			sample_s1 <= sample_in;
		end
	end

	// Result register valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			sample_out_q <= y15;
		end
	end

	// History advances exactly once per word, together with the result.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hist_q <= '0;
		end else if (fire) begin
			hist_q.prev_in_2  <= hist_q.prev_in_1;
			hist_q.prev_in_1  <= x29;
			hist_q.prev_out_2 <= hist_q.prev_out_1;
			hist_q.prev_out_1 <= y29;
		end
	end

	// Coefficient registers; unknown indexes drop.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (bqdf1_pkg::reg_idx_t'(cfg_index))
				bqdf1_pkg::REG_FF_COEF_0: coef_q.ff_coef_0 <= cfg_data;
				bqdf1_pkg::REG_FF_COEF_1: coef_q.ff_coef_1 <= cfg_data;
				bqdf1_pkg::REG_FF_COEF_2: coef_q.ff_coef_2 <= cfg_data;
				bqdf1_pkg::REG_FB_COEF_1: coef_q.fb_coef_1 <= cfg_data;
				bqdf1_pkg::REG_FB_COEF_2: coef_q.fb_coef_2 <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// A word leaving the input register always lands in the result register.
	`BQ_ASSERT_NEXT(a_fire_fills_out, fire, out_valid_q, "result register not loaded")
	// Output history shifts by one place per word.
	`BQ_ASSERT_NEXT(a_hist_out_shift, fire, hist_q.prev_out_2 == $past(hist_q.prev_out_1),
		"output history did not shift")
	// The widened input enters the input history.
	`BQ_ASSERT_NEXT(a_hist_in_load, fire, hist_q.prev_in_1 == $past(x29),
		"input history not loaded")
	// History holds while no word moves through.
	`BQ_ASSERT_NEXT(a_hist_hold, !fire, $stable(hist_q), "history changed without a word")
	// The widened input carries no fraction bits below Q15 precision.
	`BQ_ASSERT_NOW(a_x29_low_zero, valid_s1, x29[bqdf1_pkg::WIDEN_SHIFT-1:0] == '0,
		"widened input has nonzero low bits")

endmodule

FILE: rtl/bqdf1_datapath.sv
// Combinational multiply-accumulate, Q29 rescale and Q15 saturation.
// Depends on bqdf1_pkg.
module bqdf1_datapath (
	input  bqdf1_pkg::q29_t                            x29,
	input  bqdf1_pkg::coef_set_t                       coef,
	input  bqdf1_pkg::hist_t                           hist,
	output bqdf1_pkg::q29_t                            y29,
	output logic signed [bqdf1_pkg::SAMPLE_W-1:0]      y15
);

	localparam int AW = bqdf1_pkg::ACC_W;
	localparam int TW = bqdf1_pkg::COEF_W - bqdf1_pkg::WIDEN_SHIFT;

	logic signed [AW-1:0] p_ff0, p_ff1, p_ff2, p_fb1, p_fb2;
	logic signed [AW-1:0] acc;
	logic signed [TW-1:0] y_shr;
	logic                 fits;

	// Each product is exact in 64 bits; the sum wraps modulo 2^64.
	assign p_ff0 = coef.ff_coef_0 * x29;
	assign p_ff1 = coef.ff_coef_1 * hist.prev_in_1;
	assign p_ff2 = coef.ff_coef_2 * hist.prev_in_2;
	assign p_fb1 = coef.fb_coef_1 * hist.prev_out_1;
	assign p_fb2 = coef.fb_coef_2 * hist.prev_out_2;

	assign acc = p_ff0 + p_ff1 + p_ff2 - p_fb1 - p_fb2;

	// Arithmetic shift by 29, keep the low 32 bits.
	assign y29 = acc[bqdf1_pkg::FRAC_SHIFT +: bqdf1_pkg::COEF_W];

	// Drop 14 fraction bits, then clamp the remaining value to Q15.
	assign y_shr = y29[bqdf1_pkg::COEF_W-1:bqdf1_pkg::WIDEN_SHIFT];
	assign fits  = (y_shr[TW-1:bqdf1_pkg::SAMPLE_W-1] == '0) ||
	               (y_shr[TW-1:bqdf1_pkg::SAMPLE_W-1] == '1);

	always_comb begin
		if (fits) begin
			y15 = y_shr[bqdf1_pkg::SAMPLE_W-1:0];
		end else if (y_shr[TW-1]) begin
			y15 = {1'b1, {(bqdf1_pkg::SAMPLE_W-1){1'b0}}};
		end else begin
			y15 = {1'b0, {(bqdf1_pkg::SAMPLE_W-1){1'b1}}};
		end
	end

endmodule

FILE: dv/tb_top.sv
`timescale 1ns / 1ps
// Testbench for biquad_df1_q29_filter_core: directed corner words, then random filters.
// Depends on bqdf1_pkg and the core RTL; every output word is checked against a local model.

module tb_top;
	import bqdf1_pkg::*;

	localparam int CLK_PERIOD     = 10;
	localparam int LATENCY        = 2;
	localparam int NUM_COEFS      = int'(REG_FB_COEF_2) + 1;
	localparam int NUM_PHASES     = 12;
	localparam int SHOW_LIMIT     = 40;
	localparam int DRAIN_LIMIT    = 2000;
	localparam int TIMEOUT_CYCLES = 400000;

	typedef logic signed [SAMPLE_W-1:0] sample_t;
	typedef logic signed [ACC_W-1:0]    acc_t;

	localparam sample_t SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
	localparam sample_t SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};
	localparam q29_t    COEF_MAX   = 32'sh7FFF_FFFF;
	localparam q29_t    COEF_MIN   = 32'sh8000_0000;
	localparam q29_t    UNITY      = 32'sh2000_0000;	// 1.0 in Q29
	localparam q29_t    HALF       = 32'sh1000_0000;
	localparam logic [31:0] FF_SPAN = 32'h1000_0000;	// +/-0.5 for feedforward taps
	localparam logic [31:0] FB_SPAN = 32'h4000_0000;	// +/-2.0 for feedback taps

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 in_valid  = 1'b0;
	logic                 in_ready;
	sample_t              sample_in = '0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	sample_t              sample_out;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [REG_IDX_W-1:0] cfg_index = '0;
	logic [COEF_W-1:0]    cfg_data  = '0;

	// Model copy of the coefficient registers and the Q29 history.
	q29_t    coef_model [NUM_COEFS] = '{default: '0};
	hist_t   hist_model = '0;
	q29_t    corner_coefs [7] = '{COEF_MAX, COEF_MIN, '0, UNITY, -UNITY, 32'sd1, -32'sd1};
	sample_t expected_samples [$];
	int      errors = 0;
	bit      calm   = 1'b0;	// when set, neither side idles

	always #(CLK_PERIOD / 2) clk = ~clk;

	biquad_df1_q29_filter_core dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.sample_in  (sample_in),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.sample_out (sample_out),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	// Exact 32x32 signed product; it always fits in 64 bits.
	function automatic acc_t mul_q29(input q29_t a, input q29_t b);
		acc_t wa;
		acc_t wb;
		wa = a;
		wb = b;
		return wa * wb;
	endfunction

	// Advance the filter model by one input word and return the output word.
	function automatic sample_t biquad_predict(input sample_t s);
		q29_t x29;
		q29_t y29;
		q29_t y14;
		acc_t acc;
		// Widen Q15 to Q29.
		x29 = {{(COEF_W-SAMPLE_W-WIDEN_SHIFT){s[SAMPLE_W-1]}}, s, {WIDEN_SHIFT{1'b0}}};
		// The five-term sum wraps modulo 2^64.
		acc = mul_q29(coef_model[REG_FF_COEF_0], x29)
			+ mul_q29(coef_model[REG_FF_COEF_1], hist_model.prev_in_1)
			+ mul_q29(coef_model[REG_FF_COEF_2], hist_model.prev_in_2)
			- mul_q29(coef_model[REG_FB_COEF_1], hist_model.prev_out_1)
			- mul_q29(coef_model[REG_FB_COEF_2], hist_model.prev_out_2);
		// Arithmetic shift by 29, keep the low 32 bits: the Q29 result may wrap.
		y29 = acc[FRAC_SHIFT +: COEF_W];
		hist_model.prev_in_2  = hist_model.prev_in_1;
		hist_model.prev_in_1  = x29;
		hist_model.prev_out_2 = hist_model.prev_out_1;
		hist_model.prev_out_1 = y29;
		// Back to Q15 with saturation.
		y14 = y29 >>> WIDEN_SHIFT;
		if (y14 > SAMPLE_MAX)
			return SAMPLE_MAX;
		if (y14 < SAMPLE_MIN)
			return SAMPLE_MIN;
		return y14[SAMPLE_W-1:0];
	endfunction

	// Idle length for either side: mostly none, sometimes short, rarely long.
	function automatic int pick_gap();
		int unsigned roll;
		if (calm)
			return 0;
		roll = $urandom_range(0, 99);
		if (roll < 60)
			return 0;
		if (roll < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic sample_t random_sample();
		sample_t v;
		int unsigned pick;
		pick = $urandom_range(0, 9);
		if (pick == 0) begin
			case ($urandom_range(0, 3))
				0: v = SAMPLE_MIN;
				1: v = SAMPLE_MAX;
				2: v = '0;
				default: v = '1;
			endcase
		end else if (pick < 3) begin
			// Quiet passage: small amplitude keeps stable filters out of saturation.
			v = SAMPLE_W'($urandom_range(0, 511) - 256);
		end else begin
			v = SAMPLE_W'($urandom);
		end
		return v;
	endfunction

	// Print one line per mismatch (up to a cap) and count every one.
	task automatic report_mismatch(input string what, input sample_t exp, input sample_t got);
		if (errors < SHOW_LIMIT)
			$display("[%0t] mismatch, %s: expected %0d, got %0d", $time, what, exp, got);
		errors++;
	endtask

	// Present one word and hold it until accepted. With more set and no gap drawn,
	// keep valid high so the next word follows back to back.
	task automatic send_sample(input sample_t s, input bit more);
		bit taken;
		int gap;
		in_valid  <= 1'b1;
		sample_in <= s;
		do begin
			@(negedge clk);
			taken = in_ready;
			@(posedge clk);
		end while (!taken);
		expected_samples.push_back(biquad_predict(s));
		gap = more ? pick_gap() : 0;
		if (!more || gap > 0)
			in_valid <= 1'b0;
		repeat (gap) @(posedge clk);
	endtask

	task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input q29_t data);
		bit taken;
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do begin
			@(negedge clk);
			taken = cfg_ready;
			@(posedge clk);
		end while (!taken);
		// Writes past the last register are dropped by the core.
		if (idx < NUM_COEFS)
			coef_model[idx] = data;
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// Hold the sender until every expected word has come back.
	task automatic wait_drained();
		while (expected_samples.size() != 0)
			@(posedge clk);
		repeat (LATENCY) @(posedge clk);
	endtask

	task automatic set_filter(input q29_t ff0, input q29_t ff1, input q29_t ff2,
			input q29_t fb1, input q29_t fb2);
		write_reg(REG_FF_COEF_0, ff0);
		write_reg(REG_FF_COEF_1, ff1);
		write_reg(REG_FF_COEF_2, ff2);
		write_reg(REG_FB_COEF_1, fb1);
		write_reg(REG_FB_COEF_2, fb2);
	endtask

	task automatic play_samples(input sample_t vals [$]);
		foreach (vals[i])
			send_sample(vals[i], i != vals.size() - 1);
		wait_drained();
	endtask

	// Right after reset: only the taps on old input and old output are set, so the
	// first word comes out zero only if history and the other taps were cleared.
	task automatic test_reset_state();
		write_reg(REG_FF_COEF_1, UNITY);
		write_reg(REG_FB_COEF_1, HALF);
		play_samples('{SAMPLE_MAX, SAMPLE_MIN, 16'sd12345});
	endtask

	// Unity gain on the current input: output equals input, including the extremes.
	task automatic test_passthrough();
		set_filter(UNITY, '0, '0, '0, '0);
		play_samples('{SAMPLE_MIN, SAMPLE_MAX, 16'sd0, -16'sd1, 16'sd1});
	endtask

	// Full-scale taps: the Q29 result wraps and the output saturates.
	task automatic test_coef_extremes();
		set_filter(COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX);
		play_samples('{SAMPLE_MAX, SAMPLE_MIN, SAMPLE_MAX});
		set_filter(COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN);
		play_samples('{SAMPLE_MIN, SAMPLE_MIN, SAMPLE_MAX});
		set_filter(COEF_MIN, COEF_MIN, COEF_MIN, COEF_MAX, COEF_MAX);
		play_samples('{SAMPLE_MAX, SAMPLE_MIN, SAMPLE_MAX});
		// Integrator y = x + y1: runs into the positive rail.
		set_filter(UNITY, '0, '0, -UNITY, '0);
		play_samples('{SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX});
	endtask

	// Writes to indexes past the last register must leave the filter alone.
	task automatic test_unknown_index();
		set_filter(HALF, HALF, -HALF, HALF, -HALF);
		for (int k = NUM_COEFS; k < 2 ** REG_IDX_W; k++)
			write_reg(k[REG_IDX_W-1:0], $urandom);
		play_samples('{16'sd20000, -16'sd7, SAMPLE_MIN});
	endtask

	// Reprogram the taps: plausible filters, fully random words, or corner values.
	task automatic program_random_filter(input int style);
		q29_t c;
		for (int k = 0; k < NUM_COEFS; k++) begin
			case (style)
				0: begin
					if (k < int'(REG_FB_COEF_1))
						c = $urandom_range(0, 2 * FF_SPAN - 1) - FF_SPAN;
					else
						c = $urandom_range(0, 2 * FB_SPAN - 1) - FB_SPAN;
				end
				1: c = $urandom;
				default: c = corner_coefs[3'($urandom_range(0, 6))];
			endcase
			// Now and then skip a register so it keeps its old value.
			if ($urandom_range(0, 4) != 0)
				write_reg(k[REG_IDX_W-1:0], c);
		end
		if ($urandom_range(0, 2) == 0)
			write_reg(REG_IDX_W'($urandom_range(NUM_COEFS, 2 ** REG_IDX_W - 1)), $urandom);
	endtask

	task automatic test_random_filters();
		int  count;
		bit  pause;
		bit  more;
		for (int phase = 0; phase < NUM_PHASES; phase++) begin
			calm = (phase % 4 == 3);
			program_random_filter(phase % 3);
			count = $urandom_range(55, 95);
			pause = (phase % 2 == 0);
			for (int i = 0; i < count; i++) begin
				more = (i != count - 1) && !(pause && i == count / 2);
				send_sample(random_sample(), more);
				// Hold mid-stream until the core has emptied.
				if (pause && i == count / 2)
					wait_drained();
			end
			wait_drained();
		end
		calm = 1'b0;
	endtask

	// Receiver: random stalls on out_ready.
	initial begin : out_ready_driver
		int stall_left;
		stall_left = 0;
		forever begin
			@(posedge clk);
			if (stall_left > 0) begin
				out_ready <= 1'b0;
				stall_left--;
			end else begin
				stall_left = pick_gap();
				out_ready <= (stall_left == 0);
				if (stall_left > 0)
					stall_left--;
			end
		end
	end

	// Check each output word. Inputs change only at rising edges, so the values seen
	// at the falling edge are the ones the next rising edge will accept.
	always @(negedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (expected_samples.size() == 0) begin
				report_mismatch("output word with nothing expected", '0, sample_out);
			end else begin
				sample_t exp;
				exp = expected_samples.pop_front();
				if (sample_out !== exp)
					report_mismatch("sample_out", exp, sample_out);
			end
		end
	end

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_state();
		test_passthrough();
		test_coef_extremes();
		test_unknown_index();
		test_random_filters();

		// Drain with a bound, then count anything still outstanding.
		for (int n = 0; n < DRAIN_LIMIT && expected_samples.size() != 0; n++)
			@(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
		while (expected_samples.size() != 0)
			report_mismatch("expected word never came", expected_samples.pop_front(), '0);

		if (errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		#(TIMEOUT_CYCLES * CLK_PERIOD);
		$display("timeout: the core stopped moving words");
		$display("CHECKS FAILED");
		$finish;
	end

endmodule

FILE: files.f
+incdir+rtl
rtl/bqdf1_pkg.sv
rtl/bqdf1_datapath.sv
rtl/biquad_df1_q29_filter_core.sv
dv/tb_top.sv
